// ===== hw/rtl/count_min_sketch_heavy_hitter_core_macros.svh =====
// Assertion macros used by the count-min sketch back end.
`ifndef COUNT_MIN_SKETCH_HEAVY_HITTER_CORE_MACROS_SVH
`define COUNT_MIN_SKETCH_HEAVY_HITTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CMSHH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CMSHH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cmshh_pkg.sv =====
// Types and constants shared by the count-min sketch modules.
package cmshh_pkg;

	localparam int KEY_W  = 64;
	localparam int ROW_W  = 3;
	localparam int BIT_W  = 6;
	localparam int SEED_W = 15;
	localparam int EST_W  = 32;
	localparam int KLEN_W = 6;
	localparam int THR_W  = 32;

	localparam logic [1:0] MODE_COUNT = 2'd0;
	localparam logic [1:0] MODE_SEED  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic REG_KEY_LENGTH = 1'b0;
	localparam logic REG_THRESHOLD  = 1'b1;

	typedef enum logic [1:0] {
		OP_COUNT,
		OP_SEED,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_UPD,
		ST_MIN
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [ROW_W-1:0]  row;
		logic [BIT_W-1:0]  bit_pos;
		logic [SEED_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic pop;
		logic init_busy;
	} back_status_t;

endpackage

// ===== hw/rtl/cmshh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cmshh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/cmshh_front.sv =====
// Front end: accepts items, drops the ones with no effect, and queues the rest.
module cmshh_front import cmshh_pkg::*; #(
	parameter int NUM_ROWS = 7,
	parameter int KEY_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        mode,
	input  logic [KEY_W-1:0]  key,
	input  logic [ROW_W-1:0]  seed_row,
	input  logic [BIT_W-1:0]  seed_bit,
	input  logic [SEED_W-1:0] seed_value,
	input  back_status_t      status,
	output head_t             head
);

	localparam int DEPTH = 2;

	cmd_t       q_mem [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	cmd_t       cmd_in;

	always_comb begin
		cmd_in.key     = key;
		cmd_in.row     = seed_row;
		cmd_in.bit_pos = seed_bit;
		cmd_in.value   = seed_value;
		cmd_in.op      = OP_COUNT;
		keep           = 1'b0;
		unique case (mode)
			MODE_COUNT: begin
				cmd_in.op = OP_COUNT;
				keep      = 1'b1;
			end
			MODE_SEED: begin
				cmd_in.op = OP_SEED;
				keep      = (int'(seed_row) < NUM_ROWS) && (int'(seed_bit) < KEY_BITS);
			end
			MODE_CLEAR: begin
				cmd_in.op = OP_CLEAR;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item_ready = (cnt_q != 2'(DEPTH)) && !status.init_busy;
	assign push       = item_valid && item_ready && keep;
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (status.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(status.pop);
		end
	end

endmodule

// ===== hw/rtl/cmshh_back.sv =====
// Back end: seed store, hashing, counter banks and the result register.
`include "count_min_sketch_heavy_hitter_core_macros.svh"

module cmshh_back import cmshh_pkg::*; #(
	parameter int NUM_ROWS   = 7,
	parameter int INDEX_BITS = 15,
	parameter int KEY_BITS   = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  head_t             head,
	output back_status_t      status,
	input  logic [KLEN_W-1:0] key_length,
	input  logic [THR_W-1:0]  threshold,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [EST_W-1:0]  estimate,
	output logic              heavy
);

	localparam int NB_W = 7;

	state_t                  state_q;
	state_t                  state_d;
	logic [INDEX_BITS-1:0]   clr_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [KEY_BITS-1:0]     key_mask;
	logic [INDEX_BITS-1:0]   seed_q [NUM_ROWS][KEY_BITS];
	logic [INDEX_BITS-1:0]   hash_d [NUM_ROWS];
	logic [INDEX_BITS-1:0]   idx_q [NUM_ROWS];
	logic [COUNT_BITS-1:0]   rdata [NUM_ROWS];
	logic [COUNT_BITS-1:0]   inc_d [NUM_ROWS];
	logic [COUNT_BITS-1:0]   cnt_q [NUM_ROWS];
	logic [COUNT_BITS-1:0]   min_d;
	logic [NB_W-1:0]         nbits;
	logic                    ram_we;
	logic [INDEX_BITS-1:0]   waddr [NUM_ROWS];
	logic [COUNT_BITS-1:0]   wdata [NUM_ROWS];
	logic                    res_valid_q;
	logic [EST_W-1:0]        est_q;
	logic                    heavy_q;
	logic                    res_free;
	logic                    res_load;
	logic                    seed_we;

	assign res_free = !res_valid_q || result_ready;

	// Hashed bit count, limited to the key width.
	always_comb begin
		nbits = {key_length, 1'b0};
		if (int'(nbits) > KEY_BITS) begin
			nbits = NB_W'(KEY_BITS);
		end
		for (int b = 0; b < KEY_BITS; b++) begin
			key_mask[b] = (b < int'(nbits));
		end
	end

	// H3 hash: XOR the seed of every set key bit.
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			hash_d[r] = '0;
			for (int b = 0; b < KEY_BITS; b++) begin
				if (key_q[b]) begin
					hash_d[r] = hash_d[r] ^ seed_q[r][b];
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			inc_d[r] = (rdata[r] == '1) ? rdata[r] : rdata[r] + 1'b1;
		end
		min_d = cnt_q[0];
		for (int r = 1; r < NUM_ROWS; r++) begin
			if (cnt_q[r] < min_d) begin
				min_d = cnt_q[r];
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		status.pop  = 1'b0;
		status.init_busy = 1'b0;
		seed_we     = 1'b0;
		ram_we      = 1'b0;
		res_load    = 1'b0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			waddr[r] = idx_q[r];
			wdata[r] = inc_d[r];
		end
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				for (int r = 0; r < NUM_ROWS; r++) begin
					waddr[r] = clr_q;
					wdata[r] = '0;
				end
				status.init_busy = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head.valid) begin
					status.pop = 1'b1;
					unique case (head.cmd.op)
						OP_COUNT: state_d = ST_HASH;
						OP_SEED:  seed_we = 1'b1;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_HASH: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				ram_we  = 1'b1;
				state_d = ST_MIN;
			end
			ST_MIN: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (status.pop) begin
			key_q <= head.cmd.key[KEY_BITS-1:0] & key_mask;
		end
		if (state_q == ST_HASH) begin
			idx_q <= hash_d;
		end
		if (state_q == ST_UPD) begin
			cnt_q <= inc_d;
		end
		if (res_load) begin
			est_q   <= EST_W'(min_d);
			heavy_q <= ({1'b0, EST_W'(min_d)} + 33'd1) >= {1'b0, threshold};
		end
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int b = 0; b < KEY_BITS; b++) begin
				if (seed_we && int'(head.cmd.row) == r && int'(head.cmd.bit_pos) == b) begin
					seed_q[r][b] <= INDEX_BITS'(head.cmd.value);
				end
			end
		end
	end

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_bank
		cmshh_ram #(
			.WIDTH (COUNT_BITS),
			.DEPTH (1 << INDEX_BITS)
		) u_bank (
			.clk   (clk),
			.we    (ram_we),
			.waddr (waddr[r]),
			.wdata (wdata[r]),
			.raddr (idx_q[r]),
			.rdata (rdata[r])
		);
	end

	assign result_valid = res_valid_q;
	assign estimate     = est_q;
	assign heavy        = heavy_q;

	`CMSHH_ASSERT_IMP(a_no_pop_in_clear, state_q == ST_CLEAR, !status.pop, "item taken during counter clear")
	`CMSHH_ASSERT_NXT(a_upd_then_min, state_q == ST_UPD, state_q == ST_MIN, "update not followed by min")
	`CMSHH_ASSERT_NXT(a_min_waits, state_q == ST_MIN && res_valid_q && !result_ready, state_q == ST_MIN, "result overwritten while stalled")

endmodule

// ===== hw/rtl/count_min_sketch_heavy_hitter_core.sv =====
// Top level of the count-min sketch heavy-hitter core with its register port.
//
// Items enter on the item channel (item_valid/item_ready) with a mode: a count
// item hashes its key into every row, bumps each addressed counter (saturating)
// and returns one result item on the result channel (result_valid/result_ready)
// carrying the minimum incremented count and the heavy flag. Seed writes and
// counter clears return nothing; mode three and out-of-range seed writes are
// dropped at the front.
// A two-entry queue separates the front from the back, so the front keeps
// accepting items until the queue is full while the back works or a result waits.
// In the back a count passes through dequeue, hash, bank read, update write
// and minimum, which waits until the result register is free; the registered
// read port of the counter banks calls for the bank read step. A seed write is
// done as it is dequeued. A clear sweeps every bank address in parallel, one
// address per cycle. After reset, and during the sweep of every clear item, no
// item is accepted until the sweep ends; register writes are taken at any time.
// When the receiver stalls, the finished result stays in the output register
// and the back holds the next result until it can be handed over.
// Registers: key_length at address 0, threshold at address 4.
module count_min_sketch_heavy_hitter_core import cmshh_pkg::*; #(
	parameter int NUM_ROWS   = 7,
	parameter int INDEX_BITS = 15,
	parameter int KEY_BITS   = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        mode,
	input  logic [KEY_W-1:0]  key,
	input  logic [ROW_W-1:0]  seed_row,
	input  logic [BIT_W-1:0]  seed_bit,
	input  logic [SEED_W-1:0] seed_value,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [EST_W-1:0]  estimate,
	output logic              heavy,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [KLEN_W-1:0] key_length_q;
	logic [THR_W-1:0]  threshold_q;
	logic              reg_wr;
	head_t             head;
	back_status_t      status;

	// Registers are decoded on address bit 2 only.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KLEN_W'(16);
			threshold_q  <= THR_W'(1);
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_KEY_LENGTH: key_length_q <= pwdata[KLEN_W-1:0];
				REG_THRESHOLD:  threshold_q  <= pwdata[THR_W-1:0];
				default:        key_length_q <= key_length_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_KEY_LENGTH: prdata = {{(32-KLEN_W){1'b0}}, key_length_q};
			REG_THRESHOLD:  prdata = threshold_q;
			default:        prdata = '0;
		endcase
	end

	cmshh_front #(
		.NUM_ROWS (NUM_ROWS),
		.KEY_BITS (KEY_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.key        (key),
		.seed_row   (seed_row),
		.seed_bit   (seed_bit),
		.seed_value (seed_value),
		.status     (status),
		.head       (head)
	);

	cmshh_back #(
		.NUM_ROWS   (NUM_ROWS),
		.INDEX_BITS (INDEX_BITS),
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.status       (status),
		.key_length   (key_length_q),
		.threshold    (threshold_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.estimate     (estimate),
		.heavy        (heavy)
	);

endmodule

// ===== tb/sv/tb_count_min_sketch_heavy_hitter_core.sv =====
// Self-checking testbench for the count-min sketch heavy-hitter core.
module tb_count_min_sketch_heavy_hitter_core;
	import cmshh_pkg::*;

	localparam int ROWS      = 7;
	localparam int IDX_BITS  = 15;
	localparam int STALL_MAX = 200000;
	localparam int PER_PHASE = 25;

	typedef struct {
		logic [EST_W-1:0] estimate;
		logic             heavy;
	} tally_t;

	// Mirrors the sketch: counters, seeds and both registers, and holds the tallies
	// that the core still owes us.
	class sketch_scoreboard;
		logic [EST_W-1:0]  counts[int];
		logic [SEED_W-1:0] seeds[ROWS][KEY_W];
		logic [KLEN_W-1:0] key_len;
		logic [THR_W-1:0]  thr;
		tally_t            owed[$];
		int                errors;

		function new();
			key_len = KLEN_W'(16);
			thr = THR_W'(1);
			errors = 0;
		endfunction

		function int row_index(int r, logic [KEY_W-1:0] k);
			int nb;
			logic [IDX_BITS-1:0] h;
			nb = 2 * key_len;
			if (nb > KEY_W)
				nb = KEY_W;
			h = '0;
			for (int b = 0; b < nb; b++)
				if (k[b])
					h ^= seeds[r][b][IDX_BITS-1:0];
			return r * (1 << IDX_BITS) + h;
		endfunction

		function void note_item(logic [1:0] m, logic [KEY_W-1:0] k, logic [ROW_W-1:0] r,
				logic [BIT_W-1:0] b, logic [SEED_W-1:0] v);
			int a;
			logic [EST_W-1:0] low;
			tally_t t;
			case (m)
				MODE_COUNT: begin
					low = '1;
					for (int i = 0; i < ROWS; i++) begin
						a = row_index(i, k);
						if (!counts.exists(a))
							counts[a] = '0;
						if (counts[a] != '1)
							counts[a] = counts[a] + 1;
						if (counts[a] < low)
							low = counts[a];
					end
					t.estimate = low;
					t.heavy = ({1'b0, low} + 33'd1) >= {1'b0, thr};
					owed.insert(owed.size(), t);
				end
				MODE_SEED: begin
					if (r < ROWS)
						seeds[r][b] = v;
				end
				MODE_CLEAR: counts.delete();
				default: ;
			endcase
		endfunction

		function void check_result(logic [EST_W-1:0] est, logic hv);
			tally_t t;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: estimate %0d heavy %0d", est, hv);
				return;
			end
			t = owed.pop_front();
			if (t.estimate !== est || t.heavy !== hv) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected estimate %0d heavy %0d, got %0d %0d",
						t.estimate, t.heavy, est, hv);
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	logic [1:0]        mode = MODE_COUNT;
	logic [KEY_W-1:0]  key = '0;
	logic [ROW_W-1:0]  seed_row = '0;
	logic [BIT_W-1:0]  seed_bit = '0;
	logic [SEED_W-1:0] seed_value = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic [EST_W-1:0]  estimate;
	logic              heavy;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	sketch_scoreboard sb = new();
	logic             calm = 1'b0;   // No idling on either side once this is set.
	int               stall_cnt = 0;
	logic [KEY_W-1:0] hot_keys[16];

	count_min_sketch_heavy_hitter_core i_dut (.*);

	always #1 clk = ~clk;

	// Watchdog: the reset and clear sweeps stay far below the limit.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result monitor. Outputs are sampled at the rising edge, before the core's
	// flops update, so every check sees the values that were handed over.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(estimate, heavy);
	end

	// Result receiver: stalls in random bursts until the calm part of the run.
	always begin
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			result_ready <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		result_ready <= 1'b1;
	end

	// Sends one item. The task is entered and left at a falling edge; valid stays
	// high between back-to-back items unless an idle burst is drawn.
	task automatic send_item(logic [1:0] m, logic [KEY_W-1:0] k, logic [ROW_W-1:0] r,
			logic [BIT_W-1:0] b, logic [SEED_W-1:0] v);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		key <= k;
		seed_row <= r;
		seed_bit <= b;
		seed_value <= v;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_item(m, k, r, b, v);
		@(negedge clk);
	endtask

	task automatic send_count(logic [KEY_W-1:0] k);
		send_item(MODE_COUNT, k, '0, '0, '0);
	endtask

	task automatic send_seed(logic [ROW_W-1:0] r, logic [BIT_W-1:0] b, logic [SEED_W-1:0] v);
		send_item(MODE_SEED, {$urandom, $urandom}, r, b, v);
	endtask

	// Drains the core. Each phase ends with a count, so once its tally is back
	// no clear or seed write can still be running behind it.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle; pready is always high.
	task automatic reg_write(logic reg_sel, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_sel == REG_KEY_LENGTH)
			sb.key_len = data[KLEN_W-1:0];
		else
			sb.thr = data;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_count(hot_keys[$urandom_range(0, 15)]);
		else if (pick < 80)
			send_count({$urandom, $urandom});
		else if (pick < 90)
			send_seed(ROW_W'($urandom_range(0, ROWS - 1)), BIT_W'($urandom_range(0, 63)),
				SEED_W'($urandom));
		else if (pick < 95)
			send_seed(ROW_W'(ROWS), BIT_W'($urandom_range(0, 63)), SEED_W'($urandom));
		else
			send_item(2'b11, {$urandom, $urandom}, ROW_W'($urandom), BIT_W'($urandom),
				SEED_W'($urandom));
	endtask

	logic [5:0]  klens[7] = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd20, 6'd40, 6'd32};
	logic [31:0] thrs[7]  = '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd2, 32'd1, 32'd0};

	initial begin
		for (int i = 0; i < 16; i++)
			hot_keys[i] = {$urandom, $urandom};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every seed is written before any count can read it, the extremes
		// of the seed word among them.
		for (int r = 0; r < ROWS; r++)
			for (int b = 0; b < KEY_W; b++)
				send_seed(ROW_W'(r), BIT_W'(b),
					(b == 0) ? 15'h7FFF : (b == 1) ? 15'h0 : 15'($urandom));

		// Directed part under the reset register values.
		send_count('0);
		send_count('1);
		send_count('1);
		send_count(64'hAAAA_AAAA_AAAA_AAAA);
		for (int i = 0; i < 4; i++)
			send_count(hot_keys[0]);
		send_item(2'b11, '1, '1, '1, '1);                 // mode three is dropped
		send_seed(ROW_W'(ROWS), 6'd0, 15'h1234);          // row out of range
		send_seed(3'd7, 6'd63, 15'h7FFF);
		send_count('1);
		send_seed(3'd0, 6'd63, 15'h0);
		send_seed(3'd6, 6'd0, 15'h0);
		send_count('1);
		send_item(MODE_CLEAR, '0, '0, '0, '0);
		send_count(hot_keys[0]);
		send_count(hot_keys[0]);
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < 7; p++) begin
			reg_write(REG_KEY_LENGTH, 32'(klens[p]));
			reg_write(REG_THRESHOLD, thrs[p]);
			if (p == 6)
				calm = 1'b1;
			for (int i = 0; i < PER_PHASE; i++) begin
				if ((p == 2 || p == 5) && i == PER_PHASE / 2)
					send_item(MODE_CLEAR, '0, '0, '0, '0);
				else
					random_item();
			end
			send_count(hot_keys[1]);
			drain();
		end

		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
